### sv/ilid_pkg.sv
package ilid_pkg;

  localparam int VW = 32;
  localparam int PW = 16;
  localparam int CMDW = 3;
  localparam int ECW = 7;

  typedef enum logic [CMDW-1:0] {
    CMD_READ = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } op_t;

endpackage

### sv/ilid_cell.sv
module ilid_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  ilid_pkg::op_t          op,
  input  logic [IW-1:0]          pos,
  input  logic [ilid_pkg::VW-1:0] ins_value,
  input  logic [ilid_pkg::VW-1:0] left_value,
  input  logic [ilid_pkg::VW-1:0] right_value,
  output logic [ilid_pkg::VW-1:0] value,
  output logic [ilid_pkg::VW-1:0] leaf
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [ilid_pkg::VW-1:0] value_r, value_nxt;
  logic [ilid_pkg::VW-1:0] leaf_r, leaf_nxt;

  always_comb begin
    value_nxt = value_r;
    if (op.ins) begin
      if (MY_IDX > pos) begin
        value_nxt = left_value;
      end else if (MY_IDX == pos) begin
        value_nxt = ins_value;
      end
    end else if (op.del) begin
      if (MY_IDX >= pos) begin
        value_nxt = right_value;
      end
    end
  end

  always_comb begin
    leaf_nxt = leaf_r;
    if (op.rd) begin
      leaf_nxt = (MY_IDX == pos) ? value_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    leaf_r  <= leaf_nxt;
  end

  assign value = value_r;
  assign leaf  = leaf_r;

endmodule

### sv/ilid_or_tree.sv
module ilid_or_tree #(
  parameter int N = 64
) (
  input  logic                    clk,
  input  logic [ilid_pkg::VW-1:0] leaf [N],
  output logic [ilid_pkg::VW-1:0] root
);

  localparam int LG = $clog2(N);
  localparam int NP = 1 << LG;

  logic [ilid_pkg::VW-1:0] node_r [1:NP-1];
  logic [ilid_pkg::VW-1:0] heap   [1:2*NP-1];

  always_comb begin
    for (int i = 1; i < NP; i++) begin
      heap[i] = node_r[i];
    end
    for (int j = 0; j < NP; j++) begin
      heap[NP+j] = (j < N) ? leaf[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < NP; i++) begin
      node_r[i] <= heap[2*i] | heap[2*i+1];
    end
  end

  assign root = node_r[1];

endmodule

### sv/indexed_list_insert_delete.sv
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Input channel in_*: in_tuser carries the command (read, insert at head,
// insert at tail, insert at position, delete at position), in_tdata carries
// position and item_value. Output channel out_*: one word per command with
// read_value, hit, done_res, full_refused and the entry count afterwards.
// Inserts and deletes are done in the cycle the command is taken: every cell
// holds, loads the new value, or takes its left or right neighbor at once.
// A read masks the selected cell and ORs all cells through a registered tree
// of clog2(CAPACITY) levels.
// A command goes from accept through the wait state into the output register;
// a read also waits out the leaf register and the tree levels. One command is
// in flight at a time, so the next is taken only once its result is registered.
// The result sits in an output register; the next command is taken while it
// waits. If the receiver stalls with a result still held, the next result
// waits inside until out_tready frees the register.
// Reset (rst_n low, synchronous) empties the list; cell contents are kept.
module indexed_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position[15:0], item_value[47:16]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], hit[32], done_res[33],
                                  // full_refused[34], entry_count[41:35], zero
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int LG   = $clog2(CAPACITY);
  localparam int CW   = $clog2(LG + 1);
  localparam int XW   = (CNTW > ilid_pkg::PW) ? CNTW : ilid_pkg::PW;

  typedef enum logic {S_IDLE, S_WAIT} state_t;

  state_t                  state_r;
  logic [CW-1:0]           wait_r;
  logic [CNTW-1:0]         count_r, count_nxt;
  logic                    hit_r, done_r, full_r;
  logic                    out_valid_r;
  logic [ilid_pkg::VW-1:0] out_value_r;
  logic [CNTW-1:0]         out_count_r;
  logic                    out_hit_r, out_done_r, out_full_r;

  logic                    accept;
  logic [ilid_pkg::CMDW-1:0] cmd;
  logic [ilid_pkg::PW-1:0] pos_in;
  logic [ilid_pkg::VW-1:0] val_in;
  logic                    neg;
  logic [XW-1:0]           pos_x, cnt_x;
  logic                    is_full, in_range, is_ins, ins_ok, del_ok, rd_hit;
  logic [IW-1:0]           cell_pos;
  ilid_pkg::op_t           op;
  logic [ilid_pkg::VW-1:0] cell_value [CAPACITY];
  logic [ilid_pkg::VW-1:0] cell_leaf  [CAPACITY];
  logic [ilid_pkg::VW-1:0] root;
  logic                    finish;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign cmd    = in_tuser;
  assign pos_in = in_tdata[ilid_pkg::PW-1:0];
  assign val_in = in_tdata[ilid_pkg::PW+ilid_pkg::VW-1:ilid_pkg::PW];
  assign neg    = pos_in[ilid_pkg::PW-1];
  assign pos_x  = XW'(pos_in[ilid_pkg::PW-2:0]);
  assign cnt_x  = XW'(count_r);

  assign is_full  = (count_r == CNTW'(CAPACITY));
  assign in_range = !neg && (pos_x < cnt_x);
  assign is_ins   = (cmd == ilid_pkg::CMD_HEAD) || (cmd == ilid_pkg::CMD_TAIL) ||
                    (cmd == ilid_pkg::CMD_AT);
  assign ins_ok   = is_ins && !is_full &&
                    ((cmd != ilid_pkg::CMD_AT) || neg || (pos_x <= cnt_x));
  assign del_ok   = (cmd == ilid_pkg::CMD_DEL) && in_range;
  assign rd_hit   = (cmd == ilid_pkg::CMD_READ) && in_range;

  always_comb begin
    case (cmd)
      ilid_pkg::CMD_HEAD: cell_pos = '0;
      ilid_pkg::CMD_TAIL: cell_pos = IW'(count_r);
      ilid_pkg::CMD_AT:   cell_pos = neg ? '0 : IW'(pos_in);
      default:            cell_pos = IW'(pos_in);
    endcase
  end

  assign op.ins = accept && ins_ok;
  assign op.del = accept && del_ok;
  assign op.rd  = accept && rd_hit;

  always_comb begin
    count_nxt = count_r;
    if (op.ins) begin
      count_nxt = count_r + CNTW'(1);
    end else if (op.del) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilid_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .pos         (cell_pos),
      .ins_value   (val_in),
      .left_value  (cell_value[(g == 0) ? 0 : g-1]),
      .right_value (cell_value[(g == CAPACITY-1) ? g : g+1]),
      .value       (cell_value[g]),
      .leaf        (cell_leaf[g])
    );
  end

  ilid_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .root (root)
  );

  assign finish = (state_r == S_WAIT) && (wait_r == '0) &&
                  (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_valid_r && out_tready && !finish) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            hit_r   <= rd_hit;
            done_r  <= ins_ok || del_ok;
            full_r  <= is_ins && is_full;
            wait_r  <= rd_hit ? CW'(LG) : '0;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - CW'(1);
          end else if (finish) begin
            out_valid_r <= 1'b1;
            out_value_r <= hit_r ? root : '0;
            out_hit_r   <= hit_r;
            out_done_r  <= done_r;
            out_full_r  <= full_r;
            out_count_r <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, ilid_pkg::ECW'(out_count_r), out_full_r, out_done_r,
                       out_hit_r, out_value_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_ins && is_full |=> count_r == $past(count_r))
    else $error("refused insert changed the count");

  a_result_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WAIT))
    else $error("result appeared without a command in flight");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && (out_done_r || out_full_r)) &&
                    !(out_done_r && out_full_r))
    else $error("conflicting result flags");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_WAIT && !in_tready)
    else $error("command not taken into wait state");

endmodule

### tb/tb_indexed_list_insert_delete.sv
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete;

  localparam int LIST_CAP = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 550;

  localparam logic [2:0] CMD_READ = ilid_pkg::CMD_READ;
  localparam logic [2:0] CMD_HEAD = ilid_pkg::CMD_HEAD;
  localparam logic [2:0] CMD_TAIL = ilid_pkg::CMD_TAIL;
  localparam logic [2:0] CMD_AT   = ilid_pkg::CMD_AT;
  localparam logic [2:0] CMD_DEL  = ilid_pkg::CMD_DEL;
  localparam logic [2:0] CMD_NOP5 = 3'd5;
  localparam logic [2:0] CMD_NOP6 = 3'd6;
  localparam logic [2:0] CMD_NOP7 = 3'd7;

  typedef struct packed {
    logic [6:0]  cnt;
    logic        full;
    logic        done;
    logic        hit;
    logic [31:0] rd_val;
  } list_word_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] pos;
    logic [31:0] val;
    logic        fixed;
    list_word_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // position[15:0], item_value[47:16]
  logic [2:0]  in_tuser = '0;   // command[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // read_value[31:0], hit, done_res, full_refused,
                                // entry_count[41:35], zero

  logic [31:0] shadow_entries [0:LIST_CAP-1];
  int          shadow_len = 0;
  list_word_t  list_replies_q [$];
  dir_row_t    dir_rows [$];

  int n_err = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;

  indexed_list_insert_delete #(.CAPACITY(LIST_CAP)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic list_word_t apply_list_cmd(logic [2:0] c, logic [15:0] p,
                                                logic [31:0] v);
    list_word_t r;
    int pos;
    int slot;
    r = '0;
    pos = $signed(p);
    case (c)
      CMD_READ: begin
        if (pos >= 0 && pos < shadow_len) begin
          r.rd_val = shadow_entries[pos];
          r.hit = 1'b1;
        end
      end
      CMD_HEAD, CMD_TAIL, CMD_AT: begin
        if (shadow_len >= LIST_CAP) begin
          r.full = 1'b1;
        end else begin
          if (c == CMD_HEAD) slot = 0;
          else if (c == CMD_TAIL) slot = shadow_len;
          else slot = (pos < 0) ? 0 : pos;
          if (slot <= shadow_len) begin
            for (int i = shadow_len; i > slot; i--)
              shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[slot] = v;
            shadow_len++;
            r.done = 1'b1;
          end
        end
      end
      CMD_DEL: begin
        if (pos >= 0 && pos < shadow_len) begin
          for (int i = pos; i < shadow_len - 1; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
          r.done = 1'b1;
        end
      end
      default: ;
    endcase
    r.cnt = 7'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    n_err++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_list_word(logic [47:0] d);
    list_word_t got;
    list_word_t want;
    got = d[41:0];
    if (list_replies_q.size() == 0) begin
      report_mismatch($sformatf("word %h with nothing pending", d));
    end else begin
      want = list_replies_q.pop_front();
      if (got.rd_val !== want.rd_val)
        report_mismatch($sformatf("read_value %h, want %h", got.rd_val, want.rd_val));
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
      if (got.done !== want.done)
        report_mismatch($sformatf("done_res %b, want %b", got.done, want.done));
      if (got.full !== want.full)
        report_mismatch($sformatf("full_refused %b, want %b", got.full, want.full));
      if (got.cnt !== want.cnt)
        report_mismatch($sformatf("entry_count %0d, want %0d", got.cnt, want.cnt));
      if (d[47:42] !== '0)
        report_mismatch($sformatf("pad bits %b not zero", d[47:42]));
    end
  endtask

  task automatic send_cmd(logic [2:0] c, logic [15:0] p, logic [31:0] v,
                          logic fixed, list_word_t want);
    int gap;
    list_word_t r;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {v, p};
    do @(posedge clk); while (!in_tready);
    r = apply_list_cmd(c, p, v);
    list_replies_q.push_back(fixed ? want : r);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (list_replies_q.size() != 0) @(posedge clk);
  endtask

  function automatic dir_row_t dir_row(logic [2:0] c, logic [15:0] p, logic [31:0] v,
                                       logic fixed, logic [31:0] rv, logic h,
                                       logic d, logic f, logic [6:0] n);
    dir_row_t row;
    row.cmd = c;
    row.pos = p;
    row.val = v;
    row.fixed = fixed;
    row.want = '{cnt: n, full: f, done: d, hit: h, rd_val: rv};
    return row;
  endfunction

  function automatic logic [2:0] pick_cmd(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 15) return CMD_HEAD;
      if (r < 35) return CMD_TAIL;
      if (r < 70) return CMD_AT;
      if (r < 85) return CMD_READ;
      if (r < 96) return CMD_DEL;
    end else begin
      if (r < 3) return CMD_HEAD;
      if (r < 6) return CMD_TAIL;
      if (r < 9) return CMD_AT;
      if (r < 25) return CMD_READ;
      if (r < 95) return CMD_DEL;
    end
    return CMD_NOP5 + 3'($urandom_range(0, 2));
  endfunction

  function automatic logic [15:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'(-$urandom_range(1, 3));
    if (r == 2) return 16'(shadow_len + $urandom_range(1, 3));
    return 16'($urandom_range(0, shadow_len));
  endfunction

  function automatic logic [31:0] pick_val();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    if (r == 2) return 32'hffff_ffff;
    return $urandom;
  endfunction

  always @(posedge clk) begin : rx_stall
    int g;
    if ($urandom_range(0, 79) == 0) rx_calm <= !rx_calm;
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      g = rx_calm ? 0 : pick_gap();
      out_tready <= (g == 0);
      if (g > 0) rx_hold <= g - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_list_word(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stim
    dir_row_t   row;
    list_word_t none;
    bit         filling;
    int         n_rand;
    int         phase_items;
    int         at_edge;
    logic [2:0] c;

    none = '0;
    filling = 1'b1;
    n_rand = 0;

    // fixed rows: list goes [7fffffff] -> [80000000,7fffffff]
    // -> [ffffffff,80000000,7fffffff] -> [...,1] -> delete at position 1
    dir_rows.push_back(dir_row(CMD_READ, 16'd0,     32'd0,        1, 32'd0, 0, 0, 0, 7'd0));
    dir_rows.push_back(dir_row(CMD_DEL,  16'd0,     32'd0,        1, 32'd0, 0, 0, 0, 7'd0));
    dir_rows.push_back(dir_row(CMD_TAIL, 16'd0,     32'h7fffffff, 1, 32'd0, 0, 1, 0, 7'd1));
    dir_rows.push_back(dir_row(CMD_HEAD, 16'hffff,  32'h80000000, 1, 32'd0, 0, 1, 0, 7'd2));
    dir_rows.push_back(dir_row(CMD_AT,   16'h8000,  32'hffffffff, 1, 32'd0, 0, 1, 0, 7'd3));
    dir_rows.push_back(dir_row(CMD_AT,   16'd3,     32'd1,        1, 32'd0, 0, 1, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_AT,   16'd5,     32'd2,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_AT,   16'h7fff,  32'd2,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_READ, 16'd0,     32'hffffffff, 1, 32'hffffffff, 1, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_READ, 16'd3,     32'd0,        1, 32'd1, 1, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_READ, 16'd4,     32'd0,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_READ, 16'hffff,  32'd0,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_READ, 16'h7fff,  32'd0,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_DEL,  16'hffff,  32'd0,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_DEL,  16'd4,     32'd0,        1, 32'd0, 0, 0, 0, 7'd4));
    dir_rows.push_back(dir_row(CMD_DEL,  16'd1,     32'd0,        1, 32'd0, 0, 1, 0, 7'd3));
    dir_rows.push_back(dir_row(CMD_READ, 16'd1,     32'd0,        1, 32'h7fffffff, 1, 0, 0, 7'd3));
    dir_rows.push_back(dir_row(CMD_NOP5, 16'd0,     32'hffffffff, 1, 32'd0, 0, 0, 0, 7'd3));
    dir_rows.push_back(dir_row(CMD_NOP6, 16'hffff,  32'd5,        1, 32'd0, 0, 0, 0, 7'd3));
    dir_rows.push_back(dir_row(CMD_NOP7, 16'd1,     32'd6,        1, 32'd0, 0, 0, 0, 7'd3));
    dir_rows.push_back(dir_row(CMD_AT,   16'd1,     32'h12345678, 0, 32'd0, 0, 0, 0, 7'd0));
    dir_rows.push_back(dir_row(CMD_READ, 16'd2,     32'd0,        0, 32'd0, 0, 0, 0, 7'd0));
    dir_rows.push_back(dir_row(CMD_DEL,  16'd0,     32'd0,        0, 32'd0, 0, 0, 0, 7'd0));
    dir_rows.push_back(dir_row(CMD_READ, 16'd0,     32'd0,        0, 32'd0, 0, 0, 0, 7'd0));

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_cmd(row.cmd, row.pos, row.val, row.fixed, row.want);
    end
    hold_until_drained();

    // alternate fill (to full, then refusals) and drain (to empty, then misses)
    while (n_rand < RAND_ITEMS) begin
      phase_items = 0;
      at_edge = 0;
      while (n_rand < RAND_ITEMS && phase_items < 260 && at_edge < (filling ? 15 : 8)) begin
        c = pick_cmd(filling);
        send_cmd(c, pick_pos(), pick_val(), 1'b0, none);
        phase_items++;
        n_rand++;
        if ((filling && shadow_len == LIST_CAP) || (!filling && shadow_len == 0))
          at_edge++;
      end
      hold_until_drained();
      filling = !filling;
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### indexed_list_insert_delete.f
sv/ilid_pkg.sv
sv/ilid_cell.sv
sv/ilid_or_tree.sv
sv/indexed_list_insert_delete.sv
tb/tb_indexed_list_insert_delete.sv
